// ----- rtl/core/ipv4hf_pkg.sv -----
// package for the ipv4 header forwarder: widths, table depth, status and register codes
// no dependencies; used by rtl/core/ipv4_header_forwarder.sv
package ipv4hf_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int INDEX_W     = 3;
    localparam int MAC_W       = 48;
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 11;
    localparam int SIZE_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int MIN_FRAME   = 34;

    // result codes
    localparam logic [STATUS_W-1:0] ST_FORWARD  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUNT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_MAC = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TTL_EXP  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd2;

    localparam logic [ADDR_W-1:0] DEFAULT_ADDRESS = '0;

endpackage

// ----- rtl/core/ipv4_header_forwarder.sv -----
// ipv4 header forwarder: drop checks, route lookup, ttl and checksum rewrite
// an accepted request passes through the stage 1, stage 2 and result registers;
// throughput 1 request per cycle while out_ready does not stall the result
// the three stages move together; a stalled result holds the whole pipe, nothing is lost
// reset: asynchronous active low, clears valid bits and configuration registers
// route table entries have no reset and read as undefined until written
// depends on rtl/core/ipv4hf_pkg.sv
module ipv4_header_forwarder
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [ipv4hf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipv4hf_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [ipv4hf_pkg::LEN_W-1:0]         frame_length,
    input  logic [ipv4hf_pkg::MAC_W-1:0]         dest_mac,
    input  logic [63:0]                          ip_header_head,
    input  logic [63:0]                          ip_header_mid,
    input  logic [ipv4hf_pkg::ADDR_W-1:0]        ip_header_tail,
    input  logic [ipv4hf_pkg::INDEX_W-1:0]       entry_index,
    input  logic [ipv4hf_pkg::ADDR_W-1:0]        entry_address,
    input  logic [ipv4hf_pkg::MAC_W-1:0]         entry_next_hop,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ipv4hf_pkg::STATUS_W-1:0]      status,
    output logic [ipv4hf_pkg::MAC_W-1:0]         new_dest_mac,
    output logic [ipv4hf_pkg::MAC_W-1:0]         new_source_mac,
    output logic [7:0]                           new_ttl,
    output logic [15:0]                          new_checksum
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ipv4hf_pkg::MAC_W-1:0]  own_mac_reg;
    logic [ipv4hf_pkg::ADDR_W-1:0] ignore_addr_reg;
    logic [ipv4hf_pkg::SIZE_W-1:0] table_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg     <= '0;
            ignore_addr_reg <= '0;
            table_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipv4hf_pkg::CFG_OWN_MAC:    own_mac_reg     <= cfg_data[ipv4hf_pkg::MAC_W-1:0];
                ipv4hf_pkg::CFG_IGNORE:     ignore_addr_reg <= cfg_data[ipv4hf_pkg::ADDR_W-1:0];
                ipv4hf_pkg::CFG_TABLE_SIZE: table_size_reg  <= cfg_data[ipv4hf_pkg::SIZE_W-1:0];
                default: ;  // unused index, write is dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable: every stage moves when the result register is free
    // ------------------------------------------------------------------
    logic advance;
    logic in_accept;

    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign in_accept = in_valid && advance;

    // ------------------------------------------------------------------
    // stage 0 (ahead of stage 1 registers): early drop checks and
    // first half of the checksum sum
    // ------------------------------------------------------------------
    logic        runt_next;
    logic        wrong_mac_next;
    logic        ignored_next;
    logic [17:0] sum_a_next;
    logic [17:0] sum_b_next;

    always_comb
    begin
        runt_next      = (32'(frame_length) < ipv4hf_pkg::MIN_FRAME);
        wrong_mac_next = (dest_mac != own_mac_reg);
        ignored_next   = (ip_header_mid[31:0] == ignore_addr_reg)
                      || (ip_header_tail == ignore_addr_reg);
        // header words 0 to 3
        sum_a_next = 18'(ip_header_head[63:48]) + 18'(ip_header_head[47:32])
                   + 18'(ip_header_head[31:16]) + 18'(ip_header_head[15:0]);
        // source address and destination address words; check field left out
        sum_b_next = 18'(ip_header_mid[31:16]) + 18'(ip_header_mid[15:0])
                   + 18'(ip_header_tail[31:16]) + 18'(ip_header_tail[15:0]);
    end

    // stage 1 registers
    logic                              s1_valid_reg;
    logic                              s1_mode_reg;
    logic                              s1_runt_reg;
    logic                              s1_wrong_mac_reg;
    logic                              s1_ignored_reg;
    logic [ipv4hf_pkg::INDEX_W-1:0]    s1_index_reg;
    logic [ipv4hf_pkg::ADDR_W-1:0]     s1_entry_addr_reg;
    logic [ipv4hf_pkg::MAC_W-1:0]      s1_entry_hop_reg;
    logic [ipv4hf_pkg::ADDR_W-1:0]     s1_dest_ip_reg;
    logic [7:0]                        s1_ttl_reg;
    logic [7:0]                        s1_proto_reg;
    logic [17:0]                       s1_sum_a_reg;
    logic [17:0]                       s1_sum_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg       <= mode;
            s1_runt_reg       <= runt_next;
            s1_wrong_mac_reg  <= wrong_mac_next;
            s1_ignored_reg    <= ignored_next;
            s1_index_reg      <= entry_index;
            s1_entry_addr_reg <= entry_address;
            s1_entry_hop_reg  <= entry_next_hop;
            s1_dest_ip_reg    <= ip_header_tail;
            s1_ttl_reg        <= ip_header_mid[63:56];
            s1_proto_reg      <= ip_header_mid[55:48];
            s1_sum_a_reg      <= sum_a_next;
            s1_sum_b_reg      <= sum_b_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: route table write and lookup; both sit in this stage so a
    // lookup sees exactly the writes that were requested before it
    // ------------------------------------------------------------------
    logic [ipv4hf_pkg::ADDR_W-1:0] route_addr_reg [ipv4hf_pkg::TABLE_DEPTH];
    logic [ipv4hf_pkg::MAC_W-1:0]  route_hop_reg  [ipv4hf_pkg::TABLE_DEPTH];

    logic s1_write;
    assign s1_write = advance && s1_valid_reg && s1_mode_reg
                   && (32'(s1_index_reg) < ipv4hf_pkg::TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            route_addr_reg[ipv4hf_pkg::SLOT_W'(s1_index_reg)] <= s1_entry_addr_reg;
            route_hop_reg[ipv4hf_pkg::SLOT_W'(s1_index_reg)]  <= s1_entry_hop_reg;
        end
    end

    logic                         found_next;
    logic                         have_default_next;
    logic [ipv4hf_pkg::MAC_W-1:0] match_hop;
    logic [ipv4hf_pkg::MAC_W-1:0] default_hop;
    logic [ipv4hf_pkg::MAC_W-1:0] hop_next;
    logic [7:0]                   ttl_dec_next;
    logic [19:0]                  sum_next;

    always_comb
    begin
        found_next        = 1'b0;
        have_default_next = 1'b0;
        match_hop         = '0;
        default_hop       = '0;
        // first exact match wins: scan from the top down
        for (int i = ipv4hf_pkg::TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if ((i < 32'(table_size_reg)) && (route_addr_reg[i] == s1_dest_ip_reg))
            begin
                found_next = 1'b1;
                match_hop  = route_hop_reg[i];
            end
        end
        // last default entry in use wins: scan from the bottom up
        for (int i = 0; i < ipv4hf_pkg::TABLE_DEPTH; i++)
        begin
            if ((i < 32'(table_size_reg))
                && (route_addr_reg[i] == ipv4hf_pkg::DEFAULT_ADDRESS))
            begin
                have_default_next = 1'b1;
                default_hop       = route_hop_reg[i];
            end
        end
        hop_next     = found_next ? match_hop : default_hop;
        ttl_dec_next = s1_ttl_reg - 8'd1;
        sum_next     = 20'(s1_sum_a_reg) + 20'(s1_sum_b_reg)
                     + 20'({ttl_dec_next, s1_proto_reg});
    end

    // stage 2 registers
    logic                         s2_valid_reg;
    logic                         s2_mode_reg;
    logic                         s2_runt_reg;
    logic                         s2_wrong_mac_reg;
    logic                         s2_ignored_reg;
    logic                         s2_routed_reg;
    logic                         s2_ttl_low_reg;
    logic [ipv4hf_pkg::MAC_W-1:0] s2_hop_reg;
    logic [7:0]                   s2_ttl_reg;
    logic [19:0]                  s2_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_mode_reg      <= s1_mode_reg;
            s2_runt_reg      <= s1_runt_reg;
            s2_wrong_mac_reg <= s1_wrong_mac_reg;
            s2_ignored_reg   <= s1_ignored_reg;
            s2_routed_reg    <= found_next || have_default_next;
            s2_ttl_low_reg   <= (s1_ttl_reg <= 8'd1);
            s2_hop_reg       <= hop_next;
            s2_ttl_reg       <= ttl_dec_next;
            s2_sum_reg       <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: drop priority, checksum fold, zeroing of dropped results
    // ------------------------------------------------------------------
    logic [ipv4hf_pkg::STATUS_W-1:0] status_next;
    logic [16:0]                     fold_a;
    logic [15:0]                     fold_b;
    logic                            fwd;

    always_comb
    begin
        if (s2_mode_reg)
            status_next = ipv4hf_pkg::ST_WRITTEN;
        else if (s2_runt_reg)
            status_next = ipv4hf_pkg::ST_RUNT;
        else if (s2_wrong_mac_reg)
            status_next = ipv4hf_pkg::ST_WRONG_MAC;
        else if (s2_ignored_reg)
            status_next = ipv4hf_pkg::ST_IGNORED;
        else if (!s2_routed_reg)
            status_next = ipv4hf_pkg::ST_NO_ROUTE;
        else if (s2_ttl_low_reg)
            status_next = ipv4hf_pkg::ST_TTL_EXP;
        else
            status_next = ipv4hf_pkg::ST_FORWARD;

        fwd    = (status_next == ipv4hf_pkg::ST_FORWARD);
        // end-around carry, twice
        fold_a = 17'(s2_sum_reg[15:0]) + 17'(s2_sum_reg[19:16]);
        fold_b = fold_a[15:0] + 16'(fold_a[16]);
    end

    // result register
    logic                         out_valid_reg;
    logic [ipv4hf_pkg::STATUS_W-1:0] status_reg;
    logic [ipv4hf_pkg::MAC_W-1:0] new_dest_mac_reg;
    logic [ipv4hf_pkg::MAC_W-1:0] new_source_mac_reg;
    logic [7:0]                   new_ttl_reg;
    logic [15:0]                  new_checksum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            status_reg         <= status_next;
            new_dest_mac_reg   <= fwd ? s2_hop_reg : '0;
            new_source_mac_reg <= fwd ? own_mac_reg : '0;
            new_ttl_reg        <= fwd ? s2_ttl_reg : '0;
            new_checksum_reg   <= fwd ? ~fold_b : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign new_dest_mac   = new_dest_mac_reg;
    assign new_source_mac = new_source_mac_reg;
    assign new_ttl        = new_ttl_reg;
    assign new_checksum   = new_checksum_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fwd_ttl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ipv4hf_pkg::ST_FORWARD) |-> (new_ttl != 8'd0))
        else $error("forwarded result with zero ttl");

    a_drop_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ipv4hf_pkg::ST_FORWARD)
        |-> (new_dest_mac == '0 && new_source_mac == '0
             && new_ttl == 8'd0 && new_checksum == 16'd0))
        else $error("dropped result carries non-zero fields");

    a_fwd_source_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ipv4hf_pkg::ST_FORWARD) |-> (new_source_mac == own_mac_reg))
        else $error("forwarded source mac differs from router mac");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request did not enter stage 1");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while stalled");

endmodule

// ----- tb/ipv4hf_scoreboard_pkg.sv -----
// scoreboard for the ipv4 header forwarder testbench: request and result types,
// forwarding predictor with its own registers and route table, in-order result check
// depends on rtl/core/ipv4hf_pkg.sv; used by tb/tb_ipv4_header_forwarder.sv
`timescale 1ns / 1ps

package ipv4hf_scoreboard_pkg;

    import ipv4hf_pkg::*;

    typedef struct packed {
        logic                mode;
        logic [LEN_W-1:0]    frame_length;
        logic [MAC_W-1:0]    dest_mac;
        logic [63:0]         ip_header_head;
        logic [63:0]         ip_header_mid;
        logic [ADDR_W-1:0]   ip_header_tail;
        logic [INDEX_W-1:0]  entry_index;
        logic [ADDR_W-1:0]   entry_address;
        logic [MAC_W-1:0]    entry_next_hop;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MAC_W-1:0]    new_dest_mac;
        logic [MAC_W-1:0]    new_source_mac;
        logic [7:0]          new_ttl;
        logic [15:0]         new_checksum;
    } verdict_t;

    class forward_scoreboard;

        logic [MAC_W-1:0]  own_mac;
        logic [ADDR_W-1:0] ignore_address;
        logic [SIZE_W-1:0] table_size;
        logic [ADDR_W-1:0] route_address [TABLE_DEPTH];
        logic [MAC_W-1:0]  route_next_hop [TABLE_DEPTH];
        verdict_t          pending_verdicts [$];
        int unsigned       status_seen [8];
        int unsigned       mismatches;
        int unsigned       verdicts_checked;

        function new();
            own_mac          = '0;
            ignore_address   = '0;
            table_size       = '0;
            mismatches       = 0;
            verdicts_checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            foreach (route_address[i])
            begin
                route_address[i]  = '0;
                route_next_hop[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_OWN_MAC:    own_mac        = data[MAC_W-1:0];
                CFG_IGNORE:     ignore_address = data[ADDR_W-1:0];
                CFG_TABLE_SIZE: table_size     = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // checksum: complement of the ones' complement sum of the ten header words, check field as zero
        function logic [15:0] header_checksum(logic [63:0] head, logic [63:0] mid,
                                              logic [31:0] tail);
            logic [31:0] sum;
            int          k;
            sum = tail[31:16];
            sum = sum + tail[15:0];
            for (k = 0; k < 4; k++)
            begin
                sum = sum + head[63 - 16 * k -: 16];
                if (k != 1)
                    sum = sum + mid[63 - 16 * k -: 16];
            end
            sum = (sum >> 16) + (sum & 32'hFFFF);
            sum = sum + (sum >> 16);
            return ~sum[15:0];
        endfunction

        function verdict_t forward_header(request_t r);
            verdict_t          v;
            logic [MAC_W-1:0]  hop;
            logic [MAC_W-1:0]  default_hop;
            logic [7:0]        ttl;
            logic              found;
            logic              have_default;
            int                used;
            int                i;
            v            = '0;
            hop          = '0;
            default_hop  = '0;
            found        = 1'b0;
            have_default = 1'b0;

            if (r.mode)
            begin
                if (r.entry_index < TABLE_DEPTH)
                begin
                    route_address[r.entry_index]  = r.entry_address;
                    route_next_hop[r.entry_index] = r.entry_next_hop;
                end
                v.status = ST_WRITTEN;
                return v;
            end

            if (r.frame_length < MIN_FRAME)
            begin
                v.status = ST_RUNT;
                return v;
            end
            if (r.dest_mac != own_mac)
            begin
                v.status = ST_WRONG_MAC;
                return v;
            end
            if (r.ip_header_mid[31:0] == ignore_address || r.ip_header_tail == ignore_address)
            begin
                v.status = ST_IGNORED;
                return v;
            end

            // first exact match wins, otherwise the last default entry seen
            used = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
            for (i = 0; i < used && !found; i++)
            begin
                if (route_address[i] == r.ip_header_tail)
                begin
                    found = 1'b1;
                    hop   = route_next_hop[i];
                end
                else if (route_address[i] == DEFAULT_ADDRESS)
                begin
                    have_default = 1'b1;
                    default_hop  = route_next_hop[i];
                end
            end
            if (!found)
            begin
                if (!have_default)
                begin
                    v.status = ST_NO_ROUTE;
                    return v;
                end
                hop = default_hop;
            end

            ttl = r.ip_header_mid[63:56];
            if (ttl <= 8'd1)
            begin
                v.status = ST_TTL_EXP;
                return v;
            end
            ttl = ttl - 8'd1;

            v.status         = ST_FORWARD;
            v.new_dest_mac   = hop;
            v.new_source_mac = own_mac;
            v.new_ttl        = ttl;
            v.new_checksum   = header_checksum(r.ip_header_head,
                                               {ttl, r.ip_header_mid[55:0]},
                                               r.ip_header_tail);
            return v;
        endfunction

        function void note_request(request_t r);
            verdict_t v;
            v = forward_header(r);
            status_seen[v.status]++;
            pending_verdicts.push_back(v);
        endfunction

        // one line per mismatch, and a running count
        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result with status %0d and nothing pending",
                                          got.status));
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                          verdicts_checked, got.status, want.status));
            if (got.new_dest_mac !== want.new_dest_mac)
                report_mismatch($sformatf("result %0d new_dest_mac: got %h, expected %h",
                                          verdicts_checked, got.new_dest_mac,
                                          want.new_dest_mac));
            if (got.new_source_mac !== want.new_source_mac)
                report_mismatch($sformatf("result %0d new_source_mac: got %h, expected %h",
                                          verdicts_checked, got.new_source_mac,
                                          want.new_source_mac));
            if (got.new_ttl !== want.new_ttl)
                report_mismatch($sformatf("result %0d new_ttl: got %0d, expected %0d",
                                          verdicts_checked, got.new_ttl, want.new_ttl));
            if (got.new_checksum !== want.new_checksum)
                report_mismatch($sformatf("result %0d new_checksum: got %h, expected %h",
                                          verdicts_checked, got.new_checksum,
                                          want.new_checksum));
        endtask

    endclass

endpackage

// ----- tb/tb_ipv4_header_forwarder.sv -----
// top-level testbench for the ipv4 header forwarder: directed and random requests,
// random stalls on both handshakes, results checked in order against the scoreboard
// depends on rtl/core/ipv4hf_pkg.sv and tb/ipv4hf_scoreboard_pkg.sv
`timescale 1ns / 1ps

module tb_ipv4_header_forwarder;

    import ipv4hf_pkg::*;
    import ipv4hf_scoreboard_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int LATENCY       = 3;
    localparam int SETTLE_CYCLES = LATENCY + 4;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 52;
    localparam int BURST_ITEMS   = 24;
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int WATCHDOG_NS   = 2_000_000;

    // directed set-up: router identity, dropped address and the seed route table
    localparam logic [MAC_W-1:0]  HOME_MAC    = 48'h02_1A_2B_3C_4D_5E;
    localparam logic [ADDR_W-1:0] DROPPED_IP  = 32'h0A00_0063;
    localparam logic [ADDR_W-1:0] HOST_A      = 32'h0A01_0001;
    localparam logic [ADDR_W-1:0] HOST_B      = 32'h0A01_0007;
    localparam logic [ADDR_W-1:0] STRANGER    = 32'hAC10_0505;
    localparam logic [ADDR_W-1:0] SENDER_IP   = 32'h0A02_0021;
    localparam logic [MAC_W-1:0]  HOP_BASE    = 48'h02_00_00_00_00_10;
    localparam logic [ADDR_W-1:0] SEED_ADDRESS [TABLE_DEPTH] = '{
        HOST_A, DEFAULT_ADDRESS, 32'h0A01_0002, HOST_A,
        DEFAULT_ADDRESS, 32'hFFFF_FFFF, DEFAULT_ADDRESS, HOST_B
    };

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  mode           = 1'b0;
    logic [LEN_W-1:0]      frame_length   = '0;
    logic [MAC_W-1:0]      dest_mac       = '0;
    logic [63:0]           ip_header_head = '0;
    logic [63:0]           ip_header_mid  = '0;
    logic [ADDR_W-1:0]     ip_header_tail = '0;
    logic [INDEX_W-1:0]    entry_index    = '0;
    logic [ADDR_W-1:0]     entry_address  = '0;
    logic [MAC_W-1:0]      entry_next_hop = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [MAC_W-1:0]      new_dest_mac;
    logic [MAC_W-1:0]      new_source_mac;
    logic [7:0]            new_ttl;
    logic [15:0]           new_checksum;

    // handshake between the stimulus and the result-side ready driver
    logic quiet_tail   = 1'b0;
    logic hold_results = 1'b0;
    logic holding      = 1'b0;

    forward_scoreboard fwd_board = new();

    ipv4_header_forwarder dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .frame_length   (frame_length),
        .dest_mac       (dest_mac),
        .ip_header_head (ip_header_head),
        .ip_header_mid  (ip_header_mid),
        .ip_header_tail (ip_header_tail),
        .entry_index    (entry_index),
        .entry_address  (entry_address),
        .entry_next_hop (entry_next_hop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .new_dest_mac   (new_dest_mac),
        .new_source_mac (new_source_mac),
        .new_ttl        (new_ttl),
        .new_checksum   (new_checksum)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ---------------------------------------------------------------------------
    // random values
    // ---------------------------------------------------------------------------

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------------------
    // request builders
    // ---------------------------------------------------------------------------

    // header with a plausible version, length and flags; unused entry fields random
    function automatic request_t header_request(logic [LEN_W-1:0] len, logic [MAC_W-1:0] mac,
                                                logic [ADDR_W-1:0] src,
                                                logic [ADDR_W-1:0] dst, logic [7:0] ttl);
        request_t r;
        r.mode           = 1'b0;
        r.frame_length   = len;
        r.dest_mac       = mac;
        r.ip_header_head = {16'h4500, 16'h0054, 16'($urandom), 16'h4000};
        r.ip_header_mid  = {ttl, 8'h11, 16'($urandom), src};
        r.ip_header_tail = dst;
        r.entry_index    = INDEX_W'($urandom);
        r.entry_address  = $urandom;
        r.entry_next_hop = random_mac();
        return r;
    endfunction

    // route table write; the packet fields carry junk that must be ignored
    function automatic request_t entry_request(logic [INDEX_W-1:0] slot, logic [ADDR_W-1:0] addr,
                                               logic [MAC_W-1:0] hop);
        request_t r;
        r.mode           = 1'b1;
        r.frame_length   = LEN_W'($urandom);
        r.dest_mac       = random_mac();
        r.ip_header_head = random_word();
        r.ip_header_mid  = random_word();
        r.ip_header_tail = $urandom;
        r.entry_index    = slot;
        r.entry_address  = addr;
        r.entry_next_hop = hop;
        return r;
    endfunction

    // destinations lean towards addresses already in the table so lookups hit
    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return fwd_board.route_address[$urandom_range(0, TABLE_DEPTH - 1)];
            5:             return DEFAULT_ADDRESS;
            6:             return fwd_board.ignore_address;
            default:       return $urandom;
        endcase
    endfunction

    // mostly well-formed headers addressed to the router, with a share of each drop reason
    function automatic request_t random_request();
        request_t          r;
        logic [LEN_W-1:0]  len;
        logic [MAC_W-1:0]  mac;
        logic [ADDR_W-1:0] src;
        logic [7:0]        ttl;
        if ($urandom_range(0, 7) == 0)
            return entry_request(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_address(),
                                 random_mac());
        case ($urandom_range(0, 15))
            0:       len = LEN_W'($urandom_range(0, MIN_FRAME - 1));
            1:       len = LEN_W'($urandom_range(1519, 2047));
            2:       len = LEN_W'(MIN_FRAME);
            default: len = LEN_W'($urandom_range(MIN_FRAME, 1518));
        endcase
        case ($urandom_range(0, 11))
            0:       mac = random_mac();
            1:       mac = fwd_board.own_mac ^ (48'd1 << $urandom_range(0, MAC_W - 1));
            default: mac = fwd_board.own_mac;
        endcase
        case ($urandom_range(0, 11))
            0:       src = fwd_board.ignore_address;
            1:       src = DEFAULT_ADDRESS;
            default: src = $urandom;
        endcase
        case ($urandom_range(0, 11))
            0:       ttl = 8'd0;
            1:       ttl = 8'd1;
            2:       ttl = 8'hFF;
            default: ttl = 8'($urandom_range(2, 255));
        endcase
        r = header_request(len, mac, src, pick_address(), ttl);
        if ($urandom_range(0, 1) == 1)
            r.ip_header_head = random_word();
        return r;
    endfunction

    // ---------------------------------------------------------------------------
    // drivers: every task is entered and left at a falling edge
    // ---------------------------------------------------------------------------

    task automatic send_request(input request_t r);
        in_valid       <= 1'b1;
        mode           <= r.mode;
        frame_length   <= r.frame_length;
        dest_mac       <= r.dest_mac;
        ip_header_head <= r.ip_header_head;
        ip_header_mid  <= r.ip_header_mid;
        ip_header_tail <= r.ip_header_tail;
        entry_index    <= r.entry_index;
        entry_address  <= r.entry_address;
        entry_next_hop <= r.entry_next_hop;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        fwd_board.note_request(r);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // random idle burst on the request side, none once the quiet tail starts
    task automatic maybe_gap();
        if (!quiet_tail && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 7));
    endtask

    // stop offering requests until every predicted result has come back
    task automatic wait_for_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (fwd_board.pending_verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (fwd_board.pending_verdicts.size() != 0)
            fwd_board.report_mismatch($sformatf("%0d results never arrived",
                                                fwd_board.pending_verdicts.size()));
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        fwd_board.set_register(index, data);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // only called with the pipe empty
    task automatic program_router(input logic [MAC_W-1:0] mac, input logic [ADDR_W-1:0] ignored,
                                  input logic [SIZE_W-1:0] entries);
        write_register(CFG_OWN_MAC, CFG_DATA_W'(mac));
        write_register(CFG_IGNORE, CFG_DATA_W'(ignored));
        write_register(CFG_TABLE_SIZE, CFG_DATA_W'(entries));
    endtask

    // ---------------------------------------------------------------------------
    // result side: ready pattern and monitor
    // ---------------------------------------------------------------------------

    // out_ready changes once per falling edge at most; a long hold is counted here
    initial
    begin : result_ready
        int span;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                holding      = 1'b1;
                out_ready   <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holding      = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 7);
                repeat (span - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 20);
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    initial
    begin : result_monitor
        verdict_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                seen.status         = status;
                seen.new_dest_mac   = new_dest_mac;
                seen.new_source_mac = new_source_mac;
                seen.new_ttl        = new_ttl;
                seen.new_checksum   = new_checksum;
                fwd_board.check_verdict(seen);
            end
        end
    end

    // ---------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------

    initial
    begin : stimulus
        request_t r;
        int       slot;
        int       phase;
        int       n;
        int       directed_sent;
        int       random_sent;

        directed_sent = 0;
        random_sent   = 0;

        // reset held low from the start, released once
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        program_router(HOME_MAC, DROPPED_IP, SIZE_W'(TABLE_DEPTH));

        // fill every slot first so no lookup ever touches an unwritten entry;
        // two entries share an address and three are defaults
        for (slot = 0; slot < TABLE_DEPTH; slot++)
        begin
            send_request(entry_request(INDEX_W'(slot), SEED_ADDRESS[slot], HOP_BASE + MAC_W'(slot)));
            directed_sent++;
        end

        // runt takes priority over a wrong mac
        send_request(header_request(11'd0, HOME_MAC ^ 48'd1, SENDER_IP, HOST_A, 8'd64));
        // longest runt, then the shortest good frame on a duplicated address
        send_request(header_request(11'd33, HOME_MAC, SENDER_IP, HOST_A, 8'd64));
        maybe_gap();
        send_request(header_request(11'd34, HOME_MAC, SENDER_IP, HOST_A, 8'd64));
        send_request(header_request(11'd100, HOME_MAC ^ 48'h8000_0000_0000, SENDER_IP,
                                    HOST_A, 8'd64));
        // dropped address as source, then as destination
        send_request(header_request(11'd200, HOME_MAC, DROPPED_IP, HOST_A, 8'd64));
        send_request(header_request(11'd200, HOME_MAC, SENDER_IP, DROPPED_IP, 8'd64));
        // ttl too small to forward
        send_request(header_request(11'd60, HOME_MAC, SENDER_IP, HOST_A, 8'd1));
        maybe_gap();
        send_request(header_request(11'd60, HOME_MAC, SENDER_IP, HOST_A, 8'd0));
        // oversized frame is not a drop reason; all-ones header words, top ttl
        r = header_request(11'h7FF, HOME_MAC, SENDER_IP, HOST_B, 8'hFF);
        r.ip_header_head = '1;
        send_request(r);
        // unknown destination falls back to the last default entry
        send_request(header_request(11'd1518, HOME_MAC, SENDER_IP, STRANGER, 8'd30));
        // zero destination matches the first default exactly
        send_request(header_request(11'd64, HOME_MAC, SENDER_IP, DEFAULT_ADDRESS, 8'd30));
        // all-ones addresses, zero header words, ttl down to one
        r = header_request(11'd1518, HOME_MAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2);
        r.ip_header_head = '0;
        send_request(r);
        directed_sent += 12;

        // one slot in use: no default reachable
        wait_for_results();
        program_router(HOME_MAC, DROPPED_IP, SIZE_W'(1));
        send_request(header_request(11'd64, HOME_MAC, SENDER_IP, STRANGER, 8'd30));
        send_request(header_request(11'd64, HOME_MAC, SENDER_IP, HOST_A, 8'd0));

        // table size beyond the depth saturates
        wait_for_results();
        program_router(HOME_MAC, DROPPED_IP, '1);
        send_request(header_request(11'd64, HOME_MAC, SENDER_IP, HOST_B, 8'd9));
        directed_sent += 3;

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            if (phase == PHASES - 1)
                quiet_tail = 1'b1;
            case (phase)
                0: program_router(random_mac(), $urandom, SIZE_W'(TABLE_DEPTH));
                1: program_router('0, '0, SIZE_W'(3));
                2: program_router('1, '1, '0);
                3: program_router(random_mac(),
                                  fwd_board.route_address[$urandom_range(0, TABLE_DEPTH - 1)],
                                  '1);
                4: program_router(random_mac(), $urandom, SIZE_W'($urandom_range(0, 15)));
                5: program_router(random_mac(), '0, SIZE_W'(1));
                6: program_router(random_mac(), $urandom, SIZE_W'(TABLE_DEPTH));
                default: program_router(random_mac(), $urandom,
                                        SIZE_W'($urandom_range(2, TABLE_DEPTH)));
            endcase

            if (phase == 0)
            begin
                // long result hold-off while requests keep coming back to back,
                // so the pipe fills and in_ready drops
                hold_results = 1'b1;
                while (!holding)
                    @(negedge clk);
                repeat (BURST_ITEMS) send_request(random_request());
                random_sent += BURST_ITEMS;
            end

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase pause until every outstanding result is back
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_request(random_request());
                random_sent++;
                maybe_gap();
            end
        end

        wait_for_results();

        $display("run covered %0d directed and %0d random requests, %0d results checked",
                 directed_sent, random_sent, fwd_board.verdicts_checked);
        $display("outcomes: fwd %0d runt %0d mac %0d ign %0d no-route %0d ttl %0d wr %0d",
                 fwd_board.status_seen[ST_FORWARD], fwd_board.status_seen[ST_RUNT],
                 fwd_board.status_seen[ST_WRONG_MAC], fwd_board.status_seen[ST_IGNORED],
                 fwd_board.status_seen[ST_NO_ROUTE], fwd_board.status_seen[ST_TTL_EXP],
                 fwd_board.status_seen[ST_WRITTEN]);
        if (fwd_board.mismatches == 0)
            $display("tb_ipv4_header_forwarder OK");
        else
            $display("tb_ipv4_header_forwarder NOT OK");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("tb_ipv4_header_forwarder NOT OK");
        $finish;
    end

endmodule
